FILE: hdl/cptb_pkg.sv
// shared types, constants and helpers of the cascading prescaled timer bank
package cptb_pkg;

  parameter int unsigned NUM_TIMERS = 4;
  localparam int unsigned TIMER_W   = $clog2(NUM_TIMERS);

  localparam logic [7:0]  CTRL_MASK = 8'hc7;
  localparam logic [16:0] CNT_MAX   = 17'h1ffff;

  // control byte bit positions
  localparam int unsigned CTRL_EN_BIT   = 7;
  localparam int unsigned CTRL_IRQ_BIT  = 6;
  localparam int unsigned CTRL_CASC_BIT = 2;

  typedef enum logic [1:0] {
    OP_RELOAD  = 2'd0,
    OP_CTRL    = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WRITE,
    S_TIMER,
    S_READ
  } state_e;

  typedef struct packed {
    op_e         op;
    logic [1:0]  timer_index;
    logic        byte_select;
    logic [7:0]  write_byte;
    logic [9:0]  cycle_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic [3:0]  irq_raise;
    logic [1:0]  fifo_tick;
  } out_item_t;

  // one timer's stored state as seen by the update unit
  typedef struct packed {
    logic [16:0] counter;
    logic [10:0] remainder;
    logic [15:0] reload;
    logic [7:0]  ctrl;
  } timer_state_t;

  // update unit result
  typedef struct packed {
    logic [16:0] counter;
    logic [10:0] remainder;
    logic        overflow;
    logic        irq;
  } step_res_t;

  // prescale select to shift amount: divide by 1, 64, 256, 1024
  function automatic logic [3:0] prescale_shift(input logic [1:0] sel);
    logic [3:0] sh;
    unique case (sel)
      2'd0:    sh = 4'd0;
      2'd1:    sh = 4'd6;
      2'd2:    sh = 4'd8;
      default: sh = 4'd10;
    endcase
    return sh;
  endfunction

endpackage

FILE: hdl/cptb_if.sv
// valid/ready channel interfaces for input and result items
interface cptb_in_if;
  import cptb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface cptb_out_if;
  import cptb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t item;
  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

FILE: hdl/cptb_step_unit.sv
// shared timer update unit: prescale, cascade count, saturation and reload
module cptb_step_unit (
  input  cptb_pkg::timer_state_t tmr_i,
  input  logic                   carry_i,
  input  logic                   first_i,
  input  logic [9:0]             cycles_i,
  output cptb_pkg::step_res_t    res_o
);
  import cptb_pkg::*;

  logic        en;
  logic        casc;
  logic [3:0]  sh;
  logic [11:0] p;
  logic [11:0] mask;
  logic [11:0] inc;
  logic [17:0] sum;
  logic [16:0] sat;
  logic        ovf;

  always_comb begin
    en   = tmr_i.ctrl[CTRL_EN_BIT];
    // timer 0 never cascades; it counts cycles when enabled
    casc = tmr_i.ctrl[CTRL_CASC_BIT] && !first_i;
    sh   = prescale_shift(tmr_i.ctrl[1:0]);
    p    = 12'(tmr_i.remainder) + 12'(cycles_i);
    mask = (12'd1 << sh) - 12'd1;
    // a cascaded timer gains the count even when disabled
    if (casc) begin
      inc = 12'(carry_i);
    end else if (en) begin
      inc = p >> sh;
    end else begin
      inc = '0;
    end
    sum = 18'(tmr_i.counter) + 18'(inc);
    sat = sum[17] ? CNT_MAX : sum[16:0];
    ovf = en && sat[16];

    res_o.overflow  = ovf;
    res_o.irq       = ovf && tmr_i.ctrl[CTRL_IRQ_BIT];
    res_o.remainder = (en && !casc) ? 11'(p & mask) : tmr_i.remainder;
    // reload plus the excess never exceeds 17 bits
    res_o.counter   = ovf ? (17'(tmr_i.reload) + 17'(sat[15:0])) : sat;
  end

endmodule

FILE: hdl/cascading_prescaled_timer_bank.sv
// top level of the cascading prescaled timer bank: sequencer and timer state
// A bank of NUM_TIMERS 16-bit up-counting timers with reload values and control
// bytes (prescale select, cascade, irq enable, enable). Every input item gives
// exactly one result item: the low 16 bits of the addressed timer's counter
// after the item, plus irq and audio fifo tick flags for advance items. Reload,
// control and undefined items pass through the idle, write and read states,
// with the result registered in the read state; an advance passes through
// idle, one sweep step per timer and read, with the result registered in the
// read state, because one shared update unit steps the timers in ascending
// order, one per cycle, so an overflow carries into the next timer within the
// same advance. A result sits in an output register; the next item is taken
// while it waits, and the sequencer only stalls in the read state if that
// register is still full. All timer state is cleared by reset, so no warm-up
// pass is needed.
module cascading_prescaled_timer_bank (
  input  logic            clk_i,
  input  logic            rst_ni,
  cptb_in_if.sink         in_i,
  cptb_out_if.source      out_o
);
  import cptb_pkg::*;

  // per-timer state, read at one address chosen by the sequencer
  logic [16:0] cnt_q    [NUM_TIMERS];
  logic [10:0] rem_q    [NUM_TIMERS];
  logic [15:0] reload_q [NUM_TIMERS];
  logic [7:0]  ctrl_q   [NUM_TIMERS];

  state_e       state_q, state_d;
  in_item_t     item_q;
  logic [TIMER_W-1:0] t_q, t_d;
  logic         carry_q, carry_d;
  logic [3:0]   irq_q, irq_d;
  logic [1:0]   fifo_q, fifo_d;
  logic         out_valid_q, out_valid_d;
  out_item_t    res_q;

  logic               idx_ok;
  logic [TIMER_W-1:0] addr;
  timer_state_t       rd;
  step_res_t          step;
  logic               do_write;
  logic               do_step;
  logic               do_result;
  logic               last_timer;

  // one read port into the state arrays
  assign idx_ok = 3'(item_q.timer_index) < 3'(NUM_TIMERS);
  assign addr   = (state_q == S_TIMER) ? t_q : item_q.timer_index[TIMER_W-1:0];

  always_comb begin
    rd.counter   = cnt_q[addr];
    rd.remainder = rem_q[addr];
    rd.reload    = reload_q[addr];
    rd.ctrl      = ctrl_q[addr];
  end

  assign last_timer = (t_q == TIMER_W'(NUM_TIMERS - 1));

  cptb_step_unit u_step (
    .tmr_i    (rd),
    .carry_i  (carry_q),
    .first_i  (t_q == '0),
    .cycles_i (item_q.cycle_count),
    .res_o    (step)
  );

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer: next state and strobes
  always_comb begin
    state_d     = state_q;
    t_d         = t_q;
    carry_d     = carry_q;
    irq_d       = irq_q;
    fifo_d      = fifo_q;
    out_valid_d = out_valid_q && !out_o.ready;
    do_write    = 1'b0;
    do_step     = 1'b0;
    do_result   = 1'b0;
    in_i.ready  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          t_d     = '0;
          carry_d = 1'b0;
          irq_d   = '0;
          fifo_d  = '0;
          state_d = (in_i.item.op == OP_ADVANCE) ? S_TIMER : S_WRITE;
        end
      end
      S_WRITE: begin
        do_write = 1'b1;
        state_d  = S_READ;
      end
      S_TIMER: begin
        do_step = 1'b1;
        carry_d = step.overflow;
        if (step.irq) begin
          irq_d = irq_q | (4'd1 << t_q);
        end
        // audio fifo ticks come from timers 0 and 1 only
        if (step.overflow && (t_q == TIMER_W'(0))) begin
          fifo_d[0] = 1'b1;
        end
        if (step.overflow && (t_q == TIMER_W'(1))) begin
          fifo_d[1] = 1'b1;
        end
        if (last_timer) begin
          state_d = S_READ;
        end else begin
          t_d = t_q + TIMER_W'(1);
        end
      end
      S_READ: begin
        // wait for the output register to drain
        if (!out_valid_q || out_o.ready) begin
          do_result   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t_q         <= '0;
      carry_q     <= 1'b0;
      irq_q       <= '0;
      fifo_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      t_q         <= t_d;
      carry_q     <= carry_d;
      irq_q       <= irq_d;
      fifo_q      <= fifo_d;
      out_valid_q <= out_valid_d;
    end
  end

  // captured item and result payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
      res_q  <= '0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        item_q <= in_i.item;
      end
      if (do_result) begin
        res_q.count_value <= idx_ok ? rd.counter[15:0] : 16'd0;
        res_q.irq_raise   <= irq_q;
        res_q.fifo_tick   <= fifo_q;
      end
    end
  end

  // timer state: one write address per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
        cnt_q[i]    <= '0;
        rem_q[i]    <= '0;
        reload_q[i] <= '0;
        ctrl_q[i]   <= '0;
      end
    end else if (do_step) begin
      cnt_q[addr] <= step.counter;
      rem_q[addr] <= step.remainder;
    end else if (do_write && idx_ok) begin
      if (item_q.op == OP_RELOAD) begin
        if (item_q.byte_select) begin
          reload_q[addr][15:8] <= item_q.write_byte;
        end else begin
          reload_q[addr][7:0]  <= item_q.write_byte;
        end
      end else if (item_q.op == OP_CTRL && !item_q.byte_select) begin
        // rising enable restarts the timer from its reload value
        if (!rd.ctrl[CTRL_EN_BIT] && item_q.write_byte[CTRL_EN_BIT]) begin
          cnt_q[addr] <= 17'(rd.reload);
          rem_q[addr] <= '0;
        end
        ctrl_q[addr] <= item_q.write_byte & CTRL_MASK;
      end
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.item  = res_q;

`ifndef NO_ASSERTIONS
  // an accepted advance starts the timer sweep at timer 0
  a_adv_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && in_i.item.op == OP_ADVANCE)
      |=> (state_q == S_TIMER && t_q == '0))
    else $error("advance did not start sweep at timer 0");

  // register writes never raise interrupt or fifo flags
  a_write_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && item_q.op != OP_ADVANCE) |-> (irq_q == '0 && fifo_q == '0))
    else $error("flags set by a non-advance item");

  // stored control bytes keep the unwritable bits clear
  a_ctrl_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd.ctrl & ~CTRL_MASK) == 8'd0)
    else $error("control byte holds masked bits");

  // a disabled timer never overflows
  a_no_idle_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_step && !rd.ctrl[CTRL_EN_BIT]) |-> !step.overflow)
    else $error("disabled timer overflowed");

  // the sweep ends in the result state
  a_sweep_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TIMER && last_timer) |=> state_q == S_READ)
    else $error("sweep did not hand over to result");
`endif

endmodule
